### design/assert_macros.svh
// Assertion macros shared by the flash command engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion that is switched off while reset is high.
`define CFE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds through reset.
`define CFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### design/cfe_pkg.sv
// Types, command codes and CFI query constants of the flash command engine.
`timescale 1ns / 1ps
`default_nettype none
package cfe_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ARRAY_RD,
      ST_ARRAY_WR,
      ST_ERASE,
      ST_RESP
   } fsm_state_type;

   localparam logic [7:0] CMD_NONE         = 8'h00;
   localparam logic [7:0] CMD_LOCK_BIT_SET = 8'h01;
   localparam logic [7:0] CMD_PROGRAM_ALT  = 8'h10;
   localparam logic [7:0] CMD_BLOCK_ERASE  = 8'h20;
   localparam logic [7:0] CMD_PROGRAM      = 8'h40;
   localparam logic [7:0] CMD_CLEAR_STATUS = 8'h50;
   localparam logic [7:0] CMD_LOCK_SETUP   = 8'h60;
   localparam logic [7:0] CMD_READ_STATUS  = 8'h70;
   localparam logic [7:0] CMD_READ_ID      = 8'h90;
   localparam logic [7:0] CMD_QUERY        = 8'h98;
   localparam logic [7:0] CMD_CONFIRM      = 8'hD0;
   localparam logic [7:0] CMD_WRITE_BUFFER = 8'hE8;
   localparam logic [7:0] CMD_READ_ARRAY   = 8'hFF;

   localparam logic [1:0] PH_IDLE        = 2'd0;
   localparam logic [1:0] PH_SETUP       = 2'd1;
   localparam logic [1:0] PH_BUF_DATA    = 2'd2;
   localparam logic [1:0] PH_BUF_CONFIRM = 2'd3;

   localparam logic [7:0] STS_READY     = 8'h80;
   localparam logic [7:0] STS_ERASE_ERR = 8'h20;
   localparam logic [7:0] STS_PROG_ERR  = 8'h10;

   localparam logic [2:0] CSR_BUS_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_BIG_ENDIAN  = 3'd1;
   localparam logic [2:0] CSR_READ_ONLY   = 3'd2;
   localparam logic [2:0] CSR_SECTOR_LOG2 = 3'd3;
   localparam logic [2:0] CSR_BLOCKS_M1   = 3'd4;
   localparam logic [2:0] CSR_MAKER       = 3'd5;
   localparam logic [2:0] CSR_PART        = 3'd6;

   localparam logic [1:0] BW_X16 = 2'd1;
   localparam logic [1:0] BW_X32 = 2'd2;

   localparam logic [7:0] QRY_DEVICE_SIZE = 8'h27;
   localparam logic [7:0] QRY_BUF_SIZE    = 8'h2A;
   localparam logic [7:0] QRY_BLOCKS_LO   = 8'h2D;
   localparam logic [7:0] QRY_BLOCKS_HI   = 8'h2E;
   localparam logic [7:0] QRY_SECTOR_LO   = 8'h2F;
   localparam logic [7:0] QRY_SECTOR_HI   = 8'h30;
   localparam int         QRY_FIXED_LEN   = 64;

   localparam logic [7:0] CFI_FIXED [QRY_FIXED_LEN] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h51, 8'h52, 8'h59, 8'h01, 8'h00, 8'h31, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h45, 8'h55, 8'h00, 8'h00, 8'h07,
      8'h07, 8'h0a, 8'h00, 8'h04, 8'h04, 8'h04, 8'h00, 8'h00,
      8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h50, 8'h52, 8'h49, 8'h31, 8'h30, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01
   };

endpackage
`default_nettype wire

### design/cfe_byte_ram.sv
// Single-port byte memory holding the flash array, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cfe_byte_ram #(
   parameter int ADDR_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] addr,
   input  wire logic [7:0]           wdata,
   output logic      [7:0]           rdata
);
   logic [7:0] mem [2**ADDR_BITS];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

### design/cfe_query.sv
// CFI query byte lookup with the geometry bytes formed from configuration.
`timescale 1ns / 1ps
`default_nettype none
module cfe_query #(
   parameter int QUERY_LEN = 82
) (
   input  wire logic [7:0]  idx,
   input  wire logic [1:0]  bus_width_code,
   input  wire logic [4:0]  sector_size_log2,
   input  wire logic [15:0] block_count_minus_one,
   output logic      [7:0]  qbyte
);
   import cfe_pkg::*;

   logic [16:0] blocks;
   logic [4:0]  tz;
   logic        found;
   logic [5:0]  size_sum;
   logic [31:0] slen;

   always_comb begin
      blocks = 17'(block_count_minus_one) + 17'd1;
      tz     = 5'd0;
      found  = 1'b0;
      for (int i = 0; i < 17; i++) begin
         if (!found && blocks[i]) begin
            tz    = 5'(i);
            found = 1'b1;
         end
      end
      size_sum = 6'(tz) + 6'(sector_size_log2);
      slen     = 32'd1 << sector_size_log2;
   end

   always_comb begin
      if (int'(idx) >= QUERY_LEN || int'(idx) >= QRY_FIXED_LEN) begin
         qbyte = 8'h00;
      end else begin
         case (idx)
            QRY_DEVICE_SIZE: qbyte = (size_sum > 6'd32) ? 8'd32 : 8'(size_sum);
            QRY_BUF_SIZE: begin
               qbyte = (bus_width_code == BW_X16 || bus_width_code == BW_X32) ?
                       8'h0B : 8'h08;
            end
            QRY_BLOCKS_LO: qbyte = block_count_minus_one[7:0];
            QRY_BLOCKS_HI: qbyte = block_count_minus_one[15:8];
            QRY_SECTOR_LO: qbyte = slen[15:8];
            QRY_SECTOR_HI: qbyte = slen[23:16];
            default:       qbyte = CFI_FIXED[idx[5:0]];
         endcase
      end
   end
endmodule
`default_nettype wire

### design/cfi_nor_flash_command_engine.sv
// Top level of the NOR flash command engine: command sequencer and byte datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// A command-only access strobes its result in the next cycle after the accepting edge;
// an array read or a program first steps through its bytes, then strobes its result.
// The array's single byte port moves one byte per cycle; a block erase writes every
// byte of the sector through that port. One access is taken at a time, as
// busy stays high through the rsp_valid strobe. The receiver cannot stall results.
// Reset: after reset the array is swept to 0xFF with busy high.
module cfi_nor_flash_command_engine #(
   parameter int ADDR_BITS = 16,
   parameter int QUERY_LEN = 82
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_type,
   input  wire logic [15:0] req_address,
   input  wire logic [31:0] req_write_data,
   input  wire logic [1:0]  req_access_size,
   output logic             rsp_valid,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_array_readable,
   output logic [7:0]       rsp_status_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import cfe_pkg::*;

   fsm_state_type state_ff, state_in;

   // Command machine state.
   logic [7:0]  cmd_ff, cmd_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  status_ff, status_in;
   logic [31:0] countdown_ff, countdown_in;
   logic        array_mode_ff, array_mode_in;

   // Byte sequencer: the array pointer is the one shared unit that every array read, program,
   // erase and the reset sweep step through; the byte counter serves reads and programs.
   logic [ADDR_BITS-1:0] ptr_ff, ptr_in;
   logic [ADDR_BITS-1:0] erase_mask_ff, erase_mask_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic [2:0]           nbytes_ff, nbytes_in;
   logic [31:0]          data_ff, data_in;
   logic                 is_write_ff, is_write_in;

   // Configuration registers.
   logic [1:0]  bus_width_ff;
   logic        big_endian_ff;
   logic        read_only_ff;
   logic [4:0]  sector_log2_ff;
   logic [15:0] blocks_m1_ff;
   logic [15:0] maker_ff;
   logic [15:0] part_ff;

   logic                 accept;
   logic [2:0]           req_nbytes;
   logic [ADDR_BITS-1:0] req_addr;
   logic [7:0]           req_cmd;
   logic [7:0]           qidx;
   logic [7:0]           qbyte;
   logic [4:0]           erase_log2;
   logic [ADDR_BITS-1:0] req_erase_mask;
   logic                 go_rd, go_wr, go_erase;
   logic [1:0]           rd_lane, wr_lane;

   logic                 mem_en, mem_we;
   logic [ADDR_BITS-1:0] mem_addr;
   logic [7:0]           mem_wdata, mem_rdata;

   cfe_byte_ram #(.ADDR_BITS(ADDR_BITS)) u_ram (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   cfe_query #(.QUERY_LEN(QUERY_LEN)) u_query (
      .idx                   (qidx),
      .bus_width_code        (bus_width_ff),
      .sector_size_log2      (sector_log2_ff),
      .block_count_minus_one (blocks_m1_ff),
      .qbyte                 (qbyte)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign req_addr  = ADDR_BITS'(req_address);
   assign req_cmd   = req_write_data[7:0];

   always_comb begin
      case (req_access_size)
         2'd0:    req_nbytes = 3'd1;
         2'd1:    req_nbytes = 3'd2;
         2'd2:    req_nbytes = 3'd4;
         default: req_nbytes = 3'd0;
      endcase
   end

   // Query and ID index scale with the device width; a width code of 3 is byte wide.
   always_comb begin
      case (bus_width_ff)
         BW_X16:  qidx = {1'b0, req_address[7:1]};
         BW_X32:  qidx = {2'b00, req_address[7:2]};
         default: qidx = req_address[7:0];
      endcase
   end

   // The sector can never be larger than the whole array.
   assign erase_log2     = (int'(sector_log2_ff) > ADDR_BITS) ? 5'(ADDR_BITS) :
                           sector_log2_ff;
   assign req_erase_mask = ~({ADDR_BITS{1'b1}} << erase_log2);

   assign rd_lane = 2'(cnt_ff - 3'd1);
   assign wr_lane = big_endian_ff ? 2'(nbytes_ff - 3'd1 - cnt_ff) : cnt_ff[1:0];

   // Datapath and command machine updates.
   always_comb begin
      cmd_in        = cmd_ff;
      phase_in      = phase_ff;
      status_in     = status_ff;
      countdown_in  = countdown_ff;
      array_mode_in = array_mode_ff;
      ptr_in        = ptr_ff;
      erase_mask_in = erase_mask_ff;
      cnt_in        = cnt_ff;
      nbytes_in     = nbytes_ff;
      data_in       = data_ff;
      is_write_in   = is_write_ff;
      go_rd         = 1'b0;
      go_wr         = 1'b0;
      go_erase      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ptr_in = ptr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               ptr_in      = req_addr;
               cnt_in      = 3'd0;
               nbytes_in   = req_nbytes;
               is_write_in = req_type;
               if (!req_type) begin
                  case (cmd_ff) inside
                     CMD_NONE: begin
                        if (req_nbytes == 3'd0) begin
                           data_in = 32'hFFFF_FFFF;
                        end else begin
                           data_in = 32'h0;
                           go_rd   = 1'b1;
                        end
                     end
                     CMD_BLOCK_ERASE, CMD_CLEAR_STATUS, CMD_LOCK_SETUP,
                     CMD_READ_STATUS, CMD_WRITE_BUFFER: begin
                        data_in = {24'h0, status_ff};
                     end
                     CMD_READ_ID: begin
                        if (qidx == 8'd0) begin
                           data_in = {16'h0, maker_ff};
                        end else if (qidx == 8'd1) begin
                           data_in = {16'h0, part_ff};
                        end else begin
                           data_in = 32'h0;
                        end
                     end
                     CMD_QUERY: begin
                        data_in = {24'h0, qbyte};
                     end
                     default: begin
                        // A read with no read meaning drops the command but
                        // leaves the array mode flag alone.
                        data_in  = 32'hFFFF_FFFF;
                        cmd_in   = CMD_NONE;
                        phase_in = PH_IDLE;
                     end
                  endcase
               end else begin
                  data_in = req_write_data;
                  if (phase_ff == PH_IDLE) begin
                     array_mode_in = 1'b0;
                  end
                  case (phase_ff)
                     PH_IDLE: begin
                        case (req_cmd) inside
                           CMD_PROGRAM_ALT, CMD_PROGRAM, CMD_LOCK_SETUP, CMD_QUERY: begin
                              phase_in = PH_SETUP;
                              cmd_in   = req_cmd;
                           end
                           CMD_BLOCK_ERASE: begin
                              if (read_only_ff) begin
                                 status_in = status_ff | STS_ERASE_ERR | STS_READY;
                              end else begin
                                 status_in     = status_ff | STS_READY;
                                 erase_mask_in = req_erase_mask;
                                 ptr_in        = req_addr & ~req_erase_mask;
                                 go_erase      = 1'b1;
                              end
                              phase_in = PH_SETUP;
                              cmd_in   = req_cmd;
                           end
                           CMD_CLEAR_STATUS: begin
                              status_in     = 8'h00;
                              array_mode_in = 1'b1;
                              phase_in      = PH_IDLE;
                              cmd_in        = CMD_NONE;
                           end
                           CMD_READ_STATUS, CMD_READ_ID: begin
                              cmd_in = req_cmd;
                           end
                           CMD_WRITE_BUFFER: begin
                              status_in = status_ff | STS_READY;
                              phase_in  = PH_SETUP;
                              cmd_in    = req_cmd;
                           end
                           default: begin
                              array_mode_in = 1'b1;
                              phase_in      = PH_IDLE;
                              cmd_in        = CMD_NONE;
                           end
                        endcase
                     end
                     PH_SETUP: begin
                        case (cmd_ff) inside
                           CMD_PROGRAM_ALT, CMD_PROGRAM: begin
                              if (read_only_ff) begin
                                 status_in = status_ff | STS_PROG_ERR | STS_READY;
                              end else begin
                                 status_in = status_ff | STS_READY;
                                 go_wr     = (req_nbytes != 3'd0);
                              end
                              phase_in = PH_IDLE;
                           end
                           CMD_BLOCK_ERASE: begin
                              if (req_cmd == CMD_CONFIRM) begin
                                 phase_in  = PH_IDLE;
                                 status_in = status_ff | STS_READY;
                              end else begin
                                 array_mode_in = 1'b1;
                                 phase_in      = PH_IDLE;
                                 cmd_in        = CMD_NONE;
                              end
                           end
                           CMD_WRITE_BUFFER: begin
                              countdown_in = req_write_data;
                              phase_in     = PH_BUF_DATA;
                           end
                           CMD_LOCK_SETUP: begin
                              if (req_cmd == CMD_CONFIRM || req_cmd == CMD_LOCK_BIT_SET) begin
                                 phase_in  = PH_IDLE;
                                 status_in = status_ff | STS_READY;
                              end else begin
                                 array_mode_in = 1'b1;
                                 phase_in      = PH_IDLE;
                                 cmd_in        = CMD_NONE;
                              end
                           end
                           CMD_QUERY: begin
                              if (req_cmd == CMD_READ_ARRAY) begin
                                 array_mode_in = 1'b1;
                                 phase_in      = PH_IDLE;
                                 cmd_in        = CMD_NONE;
                              end
                           end
                           default: begin
                              array_mode_in = 1'b1;
                              phase_in      = PH_IDLE;
                              cmd_in        = CMD_NONE;
                           end
                        endcase
                     end
                     PH_BUF_DATA: begin
                        if (cmd_ff != CMD_WRITE_BUFFER) begin
                           array_mode_in = 1'b1;
                           phase_in      = PH_IDLE;
                           cmd_in        = CMD_NONE;
                        end else begin
                           if (read_only_ff) begin
                              status_in = status_ff | STS_PROG_ERR | STS_READY;
                           end else begin
                              status_in = status_ff | STS_READY;
                              go_wr     = (req_nbytes != 3'd0);
                           end
                           if (countdown_ff == 32'd0) begin
                              phase_in = PH_BUF_CONFIRM;
                           end
                           countdown_in = countdown_ff - 32'd1;
                        end
                     end
                     default: begin
                        if (cmd_ff == CMD_WRITE_BUFFER && req_cmd == CMD_CONFIRM) begin
                           phase_in  = PH_IDLE;
                           status_in = status_ff | STS_READY;
                        end else begin
                           array_mode_in = 1'b1;
                           phase_in      = PH_IDLE;
                           cmd_in        = CMD_NONE;
                        end
                     end
                  endcase
               end
            end
         end
         ST_ARRAY_RD: begin
            // Address k goes out while the byte of address k-1 comes back.
            if (cnt_ff < nbytes_ff) begin
               ptr_in = ptr_ff + 1'b1;
               cnt_in = cnt_ff + 3'd1;
            end
            if (cnt_ff != 3'd0) begin
               if (big_endian_ff) begin
                  data_in = {data_ff[23:0], mem_rdata};
               end else begin
                  data_in[{rd_lane, 3'b000} +: 8] = mem_rdata;
               end
            end
         end
         ST_ARRAY_WR: begin
            ptr_in = ptr_ff + 1'b1;
            cnt_in = cnt_ff + 3'd1;
         end
         ST_ERASE: begin
            ptr_in = ptr_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (ptr_ff == {ADDR_BITS{1'b1}}) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (go_rd) begin
                  state_in = ST_ARRAY_RD;
               end else if (go_wr) begin
                  state_in = ST_ARRAY_WR;
               end else if (go_erase) begin
                  state_in = ST_ERASE;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_ARRAY_RD: begin
            if (cnt_ff == nbytes_ff) state_in = ST_RESP;
         end
         ST_ARRAY_WR: begin
            if (cnt_ff == nbytes_ff - 3'd1) state_in = ST_RESP;
         end
         ST_ERASE: begin
            if ((ptr_ff & erase_mask_ff) == erase_mask_ff) state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: memory port and result strobe.
   always_comb begin
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = ptr_ff;
      mem_wdata = 8'hFF;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR:    mem_we = 1'b1;
         ST_ARRAY_RD: mem_en = (cnt_ff < nbytes_ff);
         ST_ARRAY_WR: begin
            mem_we    = 1'b1;
            mem_wdata = data_ff[{wr_lane, 3'b000} +: 8];
         end
         ST_ERASE:    mem_we = 1'b1;
         ST_RESP:     rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   assign rsp_read_data      = is_write_ff ? 32'h0 : data_ff;
   assign rsp_array_readable = array_mode_ff;
   assign rsp_status_value   = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cmd_ff        <= CMD_NONE;
         phase_ff      <= PH_IDLE;
         status_ff     <= 8'h00;
         countdown_ff  <= 32'h0;
         array_mode_ff <= 1'b1;
         ptr_ff        <= '0;
         cnt_ff        <= 3'd0;
      end else begin
         state_ff      <= state_in;
         cmd_ff        <= cmd_in;
         phase_ff      <= phase_in;
         status_ff     <= status_in;
         countdown_ff  <= countdown_in;
         array_mode_ff <= array_mode_in;
         ptr_ff        <= ptr_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      erase_mask_ff <= erase_mask_in;
      nbytes_ff     <= nbytes_in;
      data_ff       <= data_in;
      is_write_ff   <= is_write_in;
   end

   // Configuration beats.
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_width_ff   <= 2'd0;
         big_endian_ff  <= 1'b0;
         read_only_ff   <= 1'b0;
         sector_log2_ff <= 5'd12;
         blocks_m1_ff   <= 16'd15;
         maker_ff       <= 16'h0;
         part_ff        <= 16'h0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BUS_WIDTH:   bus_width_ff   <= csr_data[1:0];
            CSR_BIG_ENDIAN:  big_endian_ff  <= csr_data[0];
            CSR_READ_ONLY:   read_only_ff   <= csr_data[0];
            CSR_SECTOR_LOG2: sector_log2_ff <= csr_data[4:0];
            CSR_BLOCKS_M1:   blocks_m1_ff   <= csr_data;
            CSR_MAKER:       maker_ff       <= csr_data;
            CSR_PART:        part_ff        <= csr_data;
            default: begin
            end
         endcase
      end
   end

   `CFE_ASSERT(a_strobe_single, clock, reset, rsp_valid |=> !rsp_valid, "result strobe longer than one cycle")
   `CFE_ASSERT(a_accept_busy, clock, reset, accept |=> busy, "accepted beat did not raise busy")
   `CFE_ASSERT(a_buffer_cmd, clock, reset, (phase_ff == PH_BUF_DATA || phase_ff == PH_BUF_CONFIRM) |-> (cmd_ff == CMD_WRITE_BUFFER), "buffer phase without buffer command")
   `CFE_ASSERT_ALWAYS(a_reset_sweep, clock, reset |=> (state_ff == ST_CLEAR), "reset did not start the array sweep")
endmodule
`default_nettype wire

### tb/cfi_nor_flash_command_engine_checker.sv
// Checker for the NOR flash command engine: predicts every response beat and compares it.
`timescale 1ns / 1ps
module cfi_nor_flash_command_engine_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_type,
   input  wire logic [15:0] req_address,
   input  wire logic [31:0] req_write_data,
   input  wire logic [1:0]  req_access_size,
   input  wire logic        rsp_valid,
   input  wire logic [31:0] rsp_read_data,
   input  wire logic        rsp_array_readable,
   input  wire logic [7:0]  rsp_status_value,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output int               fail_count,
   output int               outstanding
);
   import cfe_pkg::*;

   typedef struct packed {
      logic [31:0] data;
      logic        readable;
      logic [7:0]  status;
   } bus_answer_type;

   bus_answer_type answer_q[$];

   logic [7:0]  flash_mem [0:65535];
   logic [1:0]  bus_width;
   logic        big_end;
   logic        write_protect;
   logic [4:0]  sector_log2;
   logic [15:0] blocks_m1;
   logic [15:0] maker_id;
   logic [15:0] part_id;
   logic [7:0]  cur_cmd;
   logic [1:0]  cur_phase;
   logic [7:0]  status_bits;
   logic [31:0] words_left;
   logic        array_mode;

   assign outstanding = answer_q.size();

   function automatic logic [7:0] query_at(int unsigned idx);
      logic [63:0] slen;
      logic [31:0] n;
      int unsigned tz;
      if (idx >= 82 || idx >= QRY_FIXED_LEN) return 8'h00;
      slen = 64'd1 << sector_log2;
      case (idx)
         QRY_DEVICE_SIZE: begin
            n = {16'd0, blocks_m1} + 32'd1;
            tz = 0;
            while (tz < 17 && n[tz] == 1'b0) tz++;
            tz += sector_log2;
            return (tz > 32) ? 8'd32 : tz[7:0];
         end
         QRY_BUF_SIZE:  return (bus_width == BW_X16 || bus_width == BW_X32) ? 8'h0B : 8'h08;
         QRY_BLOCKS_LO: return blocks_m1[7:0];
         QRY_BLOCKS_HI: return blocks_m1[15:8];
         QRY_SECTOR_LO: return slen[15:8];
         QRY_SECTOR_HI: return slen[23:16];
         default:       return CFI_FIXED[idx];
      endcase
   endfunction

   function automatic logic [31:0] gather_bytes(logic [15:0] a, int n);
      logic [31:0] v;
      logic [15:0] p;
      v = 0;
      for (int k = 0; k < n; k++) begin
         p = a + k[15:0];
         if (big_end) v = (v << 8) | flash_mem[p];
         else v |= {24'd0, flash_mem[p]} << (8 * k);
      end
      return v;
   endfunction

   task automatic reset_machine();
      array_mode = 1'b1;
      cur_phase = PH_IDLE;
      cur_cmd = CMD_NONE;
   endtask

   // Program stores the bytes unless the part is write protected, which flags an error.
   task automatic program_bytes(logic [15:0] a, logic [31:0] v, int n);
      int sh;
      logic [15:0] p;
      if (!write_protect) begin
         for (int k = 0; k < n; k++) begin
            sh = big_end ? 8 * (n - 1 - k) : 8 * k;
            p = a + k[15:0];
            flash_mem[p] = v[sh +: 8];
         end
      end else begin
         status_bits |= STS_PROG_ERR;
      end
      status_bits |= STS_READY;
   endtask

   function automatic logic [31:0] predict_read(logic [15:0] a, int n);
      logic [7:0] idx;
      idx = a[7:0];
      if (bus_width == BW_X16) idx = idx >> 1;
      else if (bus_width == BW_X32) idx = idx >> 2;
      case (cur_cmd)
         CMD_NONE: return (n == 0) ? 32'hFFFF_FFFF : gather_bytes(a, n);
         CMD_BLOCK_ERASE, CMD_CLEAR_STATUS, CMD_LOCK_SETUP, CMD_READ_STATUS,
         CMD_WRITE_BUFFER: return {24'd0, status_bits};
         CMD_READ_ID: begin
            if (idx == 0) return {16'd0, maker_id};
            if (idx == 1) return {16'd0, part_id};
            return 32'd0;
         end
         CMD_QUERY: return {24'd0, query_at(idx)};
         default: begin
            // A latched command with no read meaning answers all ones and drops the command.
            cur_phase = PH_IDLE;
            cur_cmd = CMD_NONE;
            return 32'hFFFF_FFFF;
         end
      endcase
   endfunction

   task automatic predict_write(logic [15:0] a, logic [31:0] v, int n);
      logic [7:0] c;
      int unsigned e;
      int unsigned len;
      int unsigned base;
      c = v[7:0];
      if (cur_phase == PH_IDLE) array_mode = 1'b0;
      case (cur_phase)
         PH_IDLE: begin
            case (c)
               CMD_PROGRAM_ALT, CMD_PROGRAM, CMD_LOCK_SETUP, CMD_QUERY,
               CMD_BLOCK_ERASE, CMD_WRITE_BUFFER: begin
                  if (c == CMD_BLOCK_ERASE) begin
                     e = (sector_log2 > 16) ? 16 : sector_log2;
                     len = 1 << e;
                     base = a & ~(len - 1) & 32'hFFFF;
                     if (!write_protect) begin
                        for (int unsigned i = 0; i < len; i++) flash_mem[base + i] = 8'hFF;
                     end else begin
                        status_bits |= STS_ERASE_ERR;
                     end
                  end
                  if (c == CMD_BLOCK_ERASE || c == CMD_WRITE_BUFFER) status_bits |= STS_READY;
                  cur_phase = PH_SETUP;
                  cur_cmd = c;
               end
               CMD_CLEAR_STATUS: begin
                  status_bits = 8'h00;
                  reset_machine();
               end
               CMD_READ_STATUS, CMD_READ_ID: cur_cmd = c;
               default: reset_machine();
            endcase
         end
         PH_SETUP: begin
            case (cur_cmd)
               CMD_PROGRAM_ALT, CMD_PROGRAM: begin
                  program_bytes(a, v, n);
                  cur_phase = PH_IDLE;
               end
               CMD_BLOCK_ERASE: begin
                  if (c == CMD_CONFIRM) begin
                     cur_phase = PH_IDLE;
                     status_bits |= STS_READY;
                  end else reset_machine();
               end
               CMD_WRITE_BUFFER: begin
                  words_left = v;
                  cur_phase = PH_BUF_DATA;
               end
               CMD_LOCK_SETUP: begin
                  if (c == CMD_CONFIRM || c == CMD_LOCK_BIT_SET) begin
                     cur_phase = PH_IDLE;
                     status_bits |= STS_READY;
                  end else reset_machine();
               end
               CMD_QUERY: if (c == CMD_READ_ARRAY) reset_machine();
               default: reset_machine();
            endcase
         end
         PH_BUF_DATA: begin
            if (cur_cmd != CMD_WRITE_BUFFER) reset_machine();
            else begin
               program_bytes(a, v, n);
               if (words_left == 0) begin
                  cur_phase = PH_BUF_CONFIRM;
                  if (write_protect) status_bits |= STS_PROG_ERR;
               end
               words_left = words_left - 1;
            end
         end
         default: begin
            if (cur_cmd == CMD_WRITE_BUFFER && c == CMD_CONFIRM) begin
               cur_phase = PH_IDLE;
               status_bits |= STS_READY;
            end else reset_machine();
         end
      endcase
   endtask

   always @(posedge clock) begin
      bus_answer_type got;
      bus_answer_type want;
      int nbytes;
      if (reset) begin
         bus_width = 2'd0;
         big_end = 1'b0;
         write_protect = 1'b0;
         sector_log2 = 5'd12;
         blocks_m1 = 16'd15;
         maker_id = 16'd0;
         part_id = 16'd0;
         for (int i = 0; i < 65536; i++) flash_mem[i] = 8'hFF;
         cur_cmd = CMD_NONE;
         cur_phase = PH_IDLE;
         status_bits = 8'h00;
         words_left = 32'd0;
         array_mode = 1'b1;
         answer_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BUS_WIDTH:   bus_width = csr_data[1:0];
               CSR_BIG_ENDIAN:  big_end = csr_data[0];
               CSR_READ_ONLY:   write_protect = csr_data[0];
               CSR_SECTOR_LOG2: sector_log2 = csr_data[4:0];
               CSR_BLOCKS_M1:   blocks_m1 = csr_data;
               CSR_MAKER:       maker_id = csr_data;
               CSR_PART:        part_id = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            got = '{rsp_read_data, rsp_array_readable, rsp_status_value};
            if (answer_q.size() == 0) begin
               $error("response beat with no access outstanding");
               fail_count++;
            end else begin
               want = answer_q.pop_front();
               if (got.data !== want.data) begin
                  $error("read_data: expected %h, got %h", want.data, got.data);
                  fail_count++;
               end
               if (got.readable !== want.readable) begin
                  $error("array_readable: expected %b, got %b", want.readable, got.readable);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status_value: expected %h, got %h", want.status, got.status);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            nbytes = (req_access_size == 2'd0) ? 1 : (req_access_size == 2'd1) ? 2 :
                     (req_access_size == 2'd2) ? 4 : 0;
            want.data = 32'd0;
            if (req_type) predict_write(req_address, req_write_data, nbytes);
            else want.data = predict_read(req_address, nbytes);
            want.readable = array_mode;
            want.status = status_bits;
            answer_q.push_back(want);
         end
      end
   end

endmodule

### tb/cfi_nor_flash_command_engine_tb.sv
// Top of the NOR flash command engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module cfi_nor_flash_command_engine_tb;
   import cfe_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_type;
   logic [15:0] req_address;
   logic [31:0] req_write_data;
   logic [1:0]  req_access_size;
   logic        rsp_valid;
   logic [31:0] rsp_read_data;
   logic        rsp_array_readable;
   logic [7:0]  rsp_status_value;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;
   int          fail_count;
   int          outstanding;

   // Sender gaps are switched off for one phase so that back-to-back beats occur too.
   bit          gaps_on;
   // The sector length decides how costly an erase is; big sectors get few erases.
   int          cur_sector_log2;
   int          issued;

   cfi_nor_flash_command_engine dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_address(req_address),
      .req_write_data(req_write_data), .req_access_size(req_access_size),
      .rsp_valid(rsp_valid), .rsp_read_data(rsp_read_data),
      .rsp_array_readable(rsp_array_readable), .rsp_status_value(rsp_status_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   cfi_nor_flash_command_engine_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_address(req_address),
      .req_write_data(req_write_data), .req_access_size(req_access_size),
      .rsp_valid(rsp_valid), .rsp_read_data(rsp_read_data),
      .rsp_array_readable(rsp_array_readable), .rsp_status_value(rsp_status_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop. The reset sweep and the odd full-sector erase dominate the run time.
   initial begin
      #60_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // One bus access. Inputs change on the falling edge; the beat is taken at the
   // rising edge that sees busy low. Start stays high into the next access unless
   // a random gap is inserted.
   task automatic bus_access(logic kind, logic [15:0] a, logic [31:0] d, logic [1:0] sz);
      @(negedge clock);
      start = 1'b1;
      req_type = kind;
      req_address = a;
      req_write_data = d;
      req_access_size = sz;
      do @(posedge clock); while (busy);
      issued++;
      if (gaps_on && $urandom_range(0, 99) < 33) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
   endtask

   function automatic logic [15:0] pick_addr();
      case ($urandom_range(0, 9))
         0:       return 16'(16'hFFF0 + $urandom_range(0, 15));
         1, 2:    return 16'($urandom);
         default: return 16'($urandom_range(0, 511));
      endcase
   endfunction

   // Size code 3 is the odd one out and shows up about one time in ten.
   function automatic logic [1:0] pick_size();
      int r;
      r = $urandom_range(0, 9);
      return (r == 0) ? 2'd3 : 2'(r % 3);
   endfunction

   // Command writes keep random upper bits so that every data bit toggles.
   task automatic send_cmd(logic [7:0] code, logic [15:0] a);
      logic [31:0] d;
      d = $urandom;
      bus_access(1'b1, a, {d[31:8], code}, pick_size());
   endtask

   task automatic read_beat(logic [15:0] a, logic [1:0] sz);
      bus_access(1'b0, a, $urandom, sz);
   endtask

   // Stop feeding beats and let every outstanding response come back.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(logic [1:0] bw, logic be, logic ro, logic [4:0] sec,
                             logic [15:0] blk, logic [15:0] mk, logic [15:0] pt);
      write_reg(CSR_BUS_WIDTH, {14'd0, bw});
      write_reg(CSR_BIG_ENDIAN, {15'd0, be});
      write_reg(CSR_READ_ONLY, {15'd0, ro});
      write_reg(CSR_SECTOR_LOG2, {11'd0, sec});
      write_reg(CSR_BLOCKS_M1, blk);
      write_reg(CSR_MAKER, mk);
      write_reg(CSR_PART, pt);
      cur_sector_log2 = sec;
   endtask

   // Mostly well-formed command sequences with random content, plus some noise.
   task automatic random_traffic(int count);
      int stop_at;
      logic [15:0] a;
      logic [1:0] sz;
      int n;
      stop_at = issued + count;
      while (issued < stop_at) begin
         a = pick_addr();
         sz = pick_size();
         case ($urandom_range(0, 11))
            0, 1: begin
               send_cmd($urandom_range(0, 1) ? CMD_PROGRAM : CMD_PROGRAM_ALT, a);
               bus_access(1'b1, a, $urandom, sz);
               // The first read after a program hits the latched command.
               read_beat(a, sz);
               read_beat(a, sz);
            end
            2: begin
               if (cur_sector_log2 <= 12 || $urandom_range(0, 9) == 0) begin
                  send_cmd(CMD_BLOCK_ERASE, a);
                  if ($urandom_range(0, 3) == 0) send_cmd(8'($urandom), a);
                  else send_cmd(CMD_CONFIRM, a);
               end
            end
            3: begin
               send_cmd(CMD_READ_STATUS, a);
               read_beat(a, sz);
            end
            4: send_cmd(CMD_CLEAR_STATUS, a);
            5: begin
               send_cmd(CMD_READ_ID, a);
               repeat ($urandom_range(1, 3)) read_beat(16'($urandom_range(0, 15)), pick_size());
            end
            6: begin
               send_cmd(CMD_QUERY, a);
               repeat ($urandom_range(1, 4)) read_beat(16'($urandom_range(0, 255)), pick_size());
               if ($urandom_range(0, 1)) send_cmd(CMD_READ_ARRAY, a);
            end
            7: begin
               send_cmd(CMD_LOCK_SETUP, a);
               case ($urandom_range(0, 2))
                  0: send_cmd(CMD_CONFIRM, a);
                  1: send_cmd(CMD_LOCK_BIT_SET, a);
                  default: send_cmd(8'($urandom), a);
               endcase
            end
            8: begin
               n = $urandom_range(0, 3);
               send_cmd(CMD_WRITE_BUFFER, a);
               bus_access(1'b1, a, 32'(n), pick_size());
               for (int i = 0; i <= n; i++)
                  bus_access(1'b1, 16'(a + 4 * i), $urandom, sz);
               if ($urandom_range(0, 3) == 0) send_cmd(8'($urandom), a);
               else send_cmd(CMD_CONFIRM, a);
            end
            9: begin
               send_cmd(CMD_READ_ARRAY, a);
               read_beat(a, sz);
            end
            10: read_beat(a, sz);
            default: bus_access(1'($urandom_range(0, 1)), a, $urandom,
                                2'($urandom_range(0, 3)));
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_type = 1'b0;
      req_address = 16'd0;
      req_write_data = 32'd0;
      req_access_size = 2'd0;
      csr_valid = 1'b0;
      csr_index = CSR_BUS_WIDTH;
      csr_data = 16'd0;
      gaps_on = 1'b1;
      cur_sector_log2 = 12;
      issued = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      // The array is swept to all ones after reset; busy covers the sweep.
      do @(posedge clock); while (busy);

      // Directed part with the reset configuration.
      read_beat(16'h0000, 2'd0);
      read_beat(16'hFFFE, 2'd2);
      read_beat(16'h0010, 2'd3);
      send_cmd(CMD_PROGRAM, 16'hFFFE);
      bus_access(1'b1, 16'hFFFE, 32'hA5C3_0F81, 2'd2);
      read_beat(16'hFFFE, 2'd2);
      read_beat(16'hFFFF, 2'd1);
      send_cmd(CMD_READ_STATUS, 16'h0);
      read_beat(16'h0, 2'd0);
      send_cmd(CMD_CLEAR_STATUS, 16'h0);
      send_cmd(CMD_READ_ID, 16'h0);
      read_beat(16'h0000, 2'd1);
      read_beat(16'h0001, 2'd1);
      read_beat(16'h0002, 2'd0);
      send_cmd(CMD_QUERY, 16'h0);
      read_beat(16'h0027, 2'd0);
      read_beat(16'h0052, 2'd0);
      read_beat(16'h0060, 2'd0);
      send_cmd(CMD_READ_ARRAY, 16'h0);
      send_cmd(CMD_BLOCK_ERASE, 16'hFFFF);
      send_cmd(CMD_CONFIRM, 16'hFFFF);
      send_cmd(CMD_WRITE_BUFFER, 16'h0100);
      bus_access(1'b1, 16'h0100, 32'd0, 2'd0);
      bus_access(1'b1, 16'h0100, 32'hFFFF_FFFF, 2'd2);
      send_cmd(8'h33, 16'h0);
      drain();

      // Configuration phases, extremes first. The sender pauses for all responses
      // before each set of register writes.
      set_config(2'd0, 1'b0, 1'b0, 5'd8, 16'd0, 16'd0, 16'd0);
      random_traffic(190);
      drain();
      gaps_on = 1'b0;
      set_config(2'd1, 1'b1, 1'b0, 5'd9, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_traffic(190);
      drain();
      gaps_on = 1'b1;
      set_config(2'd2, 1'b0, 1'b1, 5'd10, 16'($urandom), 16'($urandom), 16'($urandom));
      random_traffic(190);
      drain();
      set_config(2'd3, 1'b1, 1'b0, 5'd16, 16'hFFFF, 16'($urandom), 16'($urandom));
      random_traffic(190);
      drain();
      set_config(2'd2, 1'b1, 1'b0, 5'd12, 16'h7FFF, 16'($urandom), 16'($urandom));
      random_traffic(190);
      drain();
      set_config(2'd1, 1'b0, 1'b1, 5'd8, 16'($urandom), 16'($urandom), 16'($urandom));
      random_traffic(190);
      drain();
      repeat (10) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### cfi_nor_flash_command_engine.f
+incdir+design
design/cfe_pkg.sv
design/cfe_byte_ram.sv
design/cfe_query.sv
design/cfi_nor_flash_command_engine.sv
tb/cfi_nor_flash_command_engine_checker.sv
tb/cfi_nor_flash_command_engine_tb.sv
